@@ rtl/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants for the character LCD terminal cursor
// Payload structs for the channels, key codes, LCD command codes, line bases.
// ----------------------------------------------------------------------------
package clt_pkg;

    // display geometry
    localparam int unsigned MAX_COLUMNS = 20;
    localparam int unsigned MAX_ROWS    = 4;
    localparam int unsigned COL_W       = 5;
    localparam int unsigned ROW_W       = 2;
    localparam int unsigned ROWS_W      = 3;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 4'd1;

    // received key codes
    localparam logic [7:0] KEY_BACKSPACE = 8'h7F;
    localparam logic [7:0] KEY_ENTER     = 8'h0D;

    // LCD codes
    localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
    localparam logic [7:0] BLANK_CHAR     = 8'h20;

    typedef struct packed {
        logic [7:0] char_code;
    } t_char_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last_write;
    } t_lcd_write;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_write;

    // DDRAM address of the first cell of each display line
    function automatic logic [7:0] line_base(input logic [ROW_W-1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

    // absolute set-cursor command, wraps in 8 bits
    function automatic logic [7:0] set_cursor_cmd(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return line_base(row) + {3'd0, col};
    endfunction

endpackage

@@ rtl/clt_stream_if.sv @@
// ----------------------------------------------------------------------------
// clt_stream_if: valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface clt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/char_lcd_terminal_cursor.sv @@
// ----------------------------------------------------------------------------
// char_lcd_terminal_cursor: received characters to character LCD write cycles
// Tracks cursor row/column and expands each character into 0..3 LCD writes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | note
//  i_chr   | in  | char_code                        | one received character
//  o_lcd   | out | is_data, bus_byte, last_write    | one LCD write per item
//  i_cfg   | in  | index, value                     | register write, always ready
//
//  A character is decoded in the cycle it is accepted; its writes sit in a
//  three-entry queue and leave one per cycle while o_lcd is ready.
//  The next character is taken in the cycle its predecessor's last write leaves.
//  Synchronous active-low reset clears the cursor and the queue, and sets the
//  column and row registers to 20 and 4.
//  A stalled o_lcd holds the queue and blocks i_chr once the queue is not empty.
// ----------------------------------------------------------------------------
module char_lcd_terminal_cursor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    clt_stream_if.sink   i_chr,
    clt_stream_if.source o_lcd,
    clt_stream_if.sink   i_cfg
);
    import clt_pkg::*;

    // registers
    logic [COL_W-1:0]  r_cols_cfg;
    logic [ROWS_W-1:0] r_rows_cfg;
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [COL_W-1:0]  r_col,  n_col;
    t_lcd_write        r_wr [3];
    t_lcd_write        n_wr [3];
    logic [1:0]        r_cnt, n_cnt;

    // decode signals
    logic [COL_W-1:0]  eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic [ROWS_W-1:0] row_inc;
    logic [ROWS_W-1:0] row_wrap;
    logic [ROW_W-1:0]  row_dec;
    logic [7:0]        cmd;
    logic              chr_take;
    logic              lcd_take;
    logic [7:0]        ch;

    assign ch       = i_chr.data.char_code;
    assign lcd_take = o_lcd.valid && o_lcd.ready;
    assign chr_take = i_chr.valid && i_chr.ready;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_chr.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_lcd.ready);
    assign o_lcd.valid = (r_cnt != 2'd0);
    assign o_lcd.data  = r_wr[0];

    // saturated geometry
    always_comb begin
        if (r_cols_cfg == '0)
            eff_cols = COL_W'(1);
        else if (r_cols_cfg > COL_W'(MAX_COLUMNS))
            eff_cols = COL_W'(MAX_COLUMNS);
        else
            eff_cols = r_cols_cfg;
        if (r_rows_cfg == '0)
            eff_rows = ROWS_W'(1);
        else if (r_rows_cfg > ROWS_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = r_rows_cfg;
    end

    // next row for enter, (row + 1) mod rows with row + 1 at most four
    assign row_inc = {1'b0, r_row} + ROWS_W'(1);
    assign row_dec = r_row - ROW_W'(1);
    always_comb begin
        case (eff_rows)
            3'd1:    row_wrap = '0;
            3'd2:    row_wrap = {2'b00, row_inc[0]};
            3'd3:    row_wrap = (row_inc >= 3'd3) ? row_inc - 3'd3 : row_inc;
            default: row_wrap = (row_inc == 3'd4) ? '0 : row_inc;
        endcase
    end

    // character decode into queued writes and next cursor
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_cnt = r_cnt;
        cmd   = '0;
        for (int i = 0; i < 3; i++) begin
            n_wr[i] = r_wr[i];
        end
        // drain one write
        if (lcd_take) begin
            n_wr[0] = r_wr[1];
            n_wr[1] = r_wr[2];
            n_cnt   = r_cnt - 2'd1;
        end
        if (chr_take) begin
            if (ch == KEY_BACKSPACE) begin
                if (r_col != '0) begin
                    n_col   = r_col - COL_W'(1);
                    n_wr[0] = '{is_data: 1'b0, bus_byte: CMD_SHIFT_LEFT, last_write: 1'b0};
                    n_wr[1] = '{is_data: 1'b1, bus_byte: BLANK_CHAR,     last_write: 1'b0};
                    n_wr[2] = '{is_data: 1'b0, bus_byte: CMD_SHIFT_LEFT, last_write: 1'b1};
                    n_cnt   = 2'd3;
                end else if (r_row != '0) begin
                    n_row   = row_dec;
                    n_col   = eff_cols - COL_W'(1);
                    cmd     = set_cursor_cmd(row_dec, eff_cols - COL_W'(1));
                    n_wr[0] = '{is_data: 1'b0, bus_byte: cmd,        last_write: 1'b0};
                    n_wr[1] = '{is_data: 1'b1, bus_byte: BLANK_CHAR, last_write: 1'b0};
                    n_wr[2] = '{is_data: 1'b0, bus_byte: cmd,        last_write: 1'b1};
                    n_cnt   = 2'd3;
                end
            end else if (ch == KEY_ENTER) begin
                n_row   = row_wrap[ROW_W-1:0];
                n_col   = '0;
                cmd     = set_cursor_cmd(row_wrap[ROW_W-1:0], '0);
                n_wr[0] = '{is_data: 1'b0, bus_byte: cmd, last_write: 1'b1};
                n_cnt   = 2'd1;
            end else begin
                if (r_col < eff_cols) begin
                    n_col   = r_col + COL_W'(1);
                    n_wr[0] = '{is_data: 1'b1, bus_byte: ch, last_write: 1'b1};
                    n_cnt   = 2'd1;
                end else if (row_inc < eff_rows) begin
                    // row full: move to the next line first
                    n_row   = row_inc[ROW_W-1:0];
                    n_col   = COL_W'(1);
                    cmd     = set_cursor_cmd(row_inc[ROW_W-1:0], '0);
                    n_wr[0] = '{is_data: 1'b0, bus_byte: cmd, last_write: 1'b0};
                    n_wr[1] = '{is_data: 1'b1, bus_byte: ch,  last_write: 1'b1};
                    n_cnt   = 2'd2;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= COL_W'(MAX_COLUMNS);
            r_rows_cfg <= ROWS_W'(MAX_ROWS);
            r_row      <= '0;
            r_col      <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.data.index == CFG_COLUMNS_IN_USE)
                    r_cols_cfg <= i_cfg.data.value[COL_W-1:0];
                else if (i_cfg.data.index == CFG_ROWS_IN_USE)
                    r_rows_cfg <= i_cfg.data.value[ROWS_W-1:0];
            end
            r_row <= n_row;
            r_col <= n_col;
            r_cnt <= n_cnt;
        end
    end

    // write queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_wr[i] <= n_wr[i];
        end
    end

`ifndef SYNTHESIS
    // no new character while more than one write is still queued
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !i_chr.ready)
        else $error("character accepted with writes still queued");

    // a stalled write keeps the queue depth
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lcd.valid && !o_lcd.ready) |=> (r_cnt == $past(r_cnt)))
        else $error("write queue changed under stall");

    // last_write marks exactly the final queued write
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lcd.valid |-> (o_lcd.data.last_write == (r_cnt == 2'd1)))
        else $error("last_write out of step with queue");

    // cursor column never passes the widest line
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(MAX_COLUMNS))
        else $error("cursor column out of range");
`endif

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: character LCD terminal cursor
// Sends received characters and register writes, predicts every LCD write
// from a cursor tracker kept here, and compares each write leaving the block.
// ----------------------------------------------------------------------------
module testbench;
    import clt_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned QUIET_CYCLES   = 4;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned HOLD_AT_CHARS  = 150;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned STEADY_FIRST   = 200;
    localparam int unsigned STEADY_LAST    = 260;
    localparam int unsigned PHASE_CHARS    = 40;

    localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    // one entry of the send queue: a character or a register write
    typedef struct {
        bit         to_cfg;
        t_char_item chr;
        t_cfg_write cfg;
    } t_terminal_stim;

    logic i_clk;
    logic i_rst_n;

    clt_stream_if #(.T(t_char_item)) chr_if ();
    clt_stream_if #(.T(t_lcd_write)) lcd_if ();
    clt_stream_if #(.T(t_cfg_write)) cfg_if ();

    char_lcd_terminal_cursor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_lcd   (lcd_if),
        .i_cfg   (cfg_if)
    );

    // send queue and expected LCD writes
    t_terminal_stim send_queue[$];
    t_lcd_write     lcd_expected[$];

    // cursor tracker state and registers
    logic [4:0] cfg_columns = 5'd20;
    logic [2:0] cfg_rows    = 3'd4;
    logic [1:0] cursor_row  = '0;
    logic [4:0] cursor_col  = '0;

    // handshake flags from the last rising edge
    bit chr_fire, cfg_fire, lcd_fire;

    int unsigned chars_taken   = 0;
    int unsigned writes_seen   = 0;
    int unsigned cfg_taken     = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_count   = 0;
    int unsigned stuck_count   = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 0;

    always #2 i_clk = ~i_clk;

    function automatic t_lcd_write lcd_write(input logic is_data, input logic [7:0] bus_byte);
        t_lcd_write w;
        w.is_data    = is_data;
        w.bus_byte   = bus_byte;
        w.last_write = 1'b0;
        return w;
    endfunction

    function automatic bit steady_stretch();
        return chars_taken >= STEADY_FIRST && chars_taken < STEADY_LAST;
    endfunction

    // cursor tracking: expected LCD writes for one character
    task automatic track_cursor(input logic [7:0] ch);
        int unsigned cols, rows, row, col;
        logic [7:0]  addr;
        t_lcd_write  w[$];
        cols = (cfg_columns == 0) ? 1 : (cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS : cfg_columns;
        rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
        row  = cursor_row;
        col  = cursor_col;
        if (ch == KEY_BACKSPACE) begin
            if (col > 0) begin
                // shift left, blank, shift left again
                col--;
                w.push_back(lcd_write(1'b0, CMD_SHIFT_LEFT));
                w.push_back(lcd_write(1'b1, BLANK_CHAR));
                w.push_back(lcd_write(1'b0, CMD_SHIFT_LEFT));
            end else if (row > 0) begin
                // back to the last column of the previous line
                row--;
                col  = cols - 1;
                addr = ROW_ADDR[row] + 8'(col);
                w.push_back(lcd_write(1'b0, addr));
                w.push_back(lcd_write(1'b1, BLANK_CHAR));
                w.push_back(lcd_write(1'b0, addr));
            end
        end else if (ch == KEY_ENTER) begin
            col = 0;
            row = (row + 1) % rows;
            w.push_back(lcd_write(1'b0, ROW_ADDR[row]));
        end else begin
            if (col < cols) begin
                w.push_back(lcd_write(1'b1, ch));
                col++;
            end else if (row + 1 < rows) begin
                // line full: move to the next line first
                row++;
                col = 1;
                w.push_back(lcd_write(1'b0, ROW_ADDR[row]));
                w.push_back(lcd_write(1'b1, ch));
            end
        end
        if (w.size() > 0)
            w[w.size()-1].last_write = 1'b1;
        foreach (w[k])
            lcd_expected.push_back(w[k]);
        cursor_row = row[1:0];
        cursor_col = col[4:0];
    endtask

    // rising edge: handshakes, tracking, checking, watchdog
    always @(posedge i_clk) begin : monitor
        t_lcd_write exp_w;
        chr_fire = chr_if.valid && chr_if.ready;
        cfg_fire = cfg_if.valid && cfg_if.ready;
        lcd_fire = lcd_if.valid && lcd_if.ready;
        if (i_rst_n) begin
            if (lcd_fire) begin
                writes_seen++;
                if (lcd_expected.size() == 0) begin
                    $error("LCD write with nothing expected: is_data=%0d bus_byte=%02h",
                           lcd_if.data.is_data, lcd_if.data.bus_byte);
                    mismatches++;
                end else begin
                    exp_w = lcd_expected.pop_front();
                    if (lcd_if.data.is_data !== exp_w.is_data) begin
                        $error("is_data: expected %0d, got %0d",
                               exp_w.is_data, lcd_if.data.is_data);
                        mismatches++;
                    end
                    if (lcd_if.data.bus_byte !== exp_w.bus_byte) begin
                        $error("bus_byte: expected %02h, got %02h",
                               exp_w.bus_byte, lcd_if.data.bus_byte);
                        mismatches++;
                    end
                    if (lcd_if.data.last_write !== exp_w.last_write) begin
                        $error("last_write: expected %0d, got %0d",
                               exp_w.last_write, lcd_if.data.last_write);
                        mismatches++;
                    end
                end
            end
            if (cfg_fire) begin
                if (cfg_if.data.index == CFG_COLUMNS_IN_USE)
                    cfg_columns = cfg_if.data.value[4:0];
                else if (cfg_if.data.index == CFG_ROWS_IN_USE)
                    cfg_rows = cfg_if.data.value[2:0];
                cfg_taken++;
                void'(send_queue.pop_front());
            end
            if (chr_fire) begin
                track_cursor(chr_if.data.char_code);
                chars_taken++;
                void'(send_queue.pop_front());
            end
            quiet_count = (chr_fire || lcd_fire) ? 0 : quiet_count + 1;
            stuck_count = (chr_fire || lcd_fire || cfg_fire) ? 0 : stuck_count + 1;
            if (stuck_count >= WATCHDOG_LIMIT) begin
                $display("Timeout: %0d cycles without an item", stuck_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // character driver
    always @(negedge i_clk) begin : drive_chars
        logic       v;
        t_char_item d;
        v = chr_if.valid;
        d = chr_if.data;
        if (i_rst_n && (!chr_if.valid || chr_fire)) begin
            v = 1'b0;
            if (send_queue.size() > 0 && !send_queue[0].to_cfg &&
                (steady_stretch() || $urandom_range(99) >= 31)) begin
                v = 1'b1;
                d = send_queue[0].chr;
            end
        end
        chr_if.valid <= v;
        chr_if.data  <= d;
    end

    // register write driver: only once the block has gone quiet
    always @(negedge i_clk) begin : drive_cfg
        logic       v;
        t_cfg_write d;
        v = cfg_if.valid;
        d = cfg_if.data;
        if (i_rst_n && (!cfg_if.valid || cfg_fire)) begin
            v = 1'b0;
            if (send_queue.size() > 0 && send_queue[0].to_cfg &&
                lcd_expected.size() == 0 && quiet_count >= QUIET_CYCLES) begin
                v = 1'b1;
                d = send_queue[0].cfg;
            end
        end
        cfg_if.valid <= v;
        cfg_if.data  <= d;
    end

    // LCD side ready: random stalls, one long hold-off, one steady stretch
    always @(negedge i_clk) begin : drive_ready
        if (hold_left > 0) begin
            hold_left--;
            lcd_if.ready <= 1'b0;
        end else if (!hold_done && chars_taken >= HOLD_AT_CHARS) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            lcd_if.ready <= 1'b0;
        end else begin
            lcd_if.ready <= steady_stretch() || ($urandom_range(99) >= 31);
        end
    end

    task automatic send_char(input logic [7:0] ch);
        t_terminal_stim s;
        s.to_cfg         = 0;
        s.chr.char_code  = ch;
        s.cfg            = '0;
        send_queue.push_back(s);
    endtask

    task automatic send_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        t_terminal_stim s;
        s.to_cfg    = 1;
        s.chr       = '0;
        s.cfg.index = idx;
        s.cfg.value = value;
        send_queue.push_back(s);
    endtask

    // random character mix: backspace and enter often, any byte otherwise
    function automatic logic [7:0] random_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return KEY_BACKSPACE;
        else if (r < 32)
            return KEY_ENTER;
        return 8'($urandom_range(255));
    endfunction

    initial begin : stimulus
        logic [4:0] phase_cols [8];
        logic [2:0] phase_rows [8];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        chr_if.valid  = 1'b0;
        chr_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        lcd_if.ready  = 1'b0;

        // directed: reset geometry 20 x 4
        send_char(KEY_BACKSPACE);           // at the origin: nothing written
        send_char(8'h00);
        send_char(8'hFF);
        send_char(KEY_BACKSPACE);           // mid-line
        send_char(KEY_ENTER);
        send_char(KEY_BACKSPACE);           // column 0 of line 1: back to line 0 end
        send_char(8'h5A);                   // fills line 0
        send_char(8'h31);                   // line full: wraps to line 1
        send_char(KEY_ENTER);
        send_char(KEY_ENTER);
        send_char(8'h80);                   // line 3, column 1
        // shrink columns under the cursor, upper value bits set
        send_cfg(CFG_COLUMNS_IN_USE, 8'hE2);
        send_char(8'h61);
        send_char(8'h62);                   // full last line: dropped
        send_char(KEY_BACKSPACE);
        send_char(KEY_ENTER);               // wraps to line 0
        send_cfg(CFG_ROWS_IN_USE, 8'hFA);
        send_char(KEY_ENTER);
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);                   // dropped on the last line
        // cursor on a line beyond a reduced line count
        send_cfg(CFG_ROWS_IN_USE, 8'h04);
        send_char(KEY_ENTER);
        send_char(KEY_ENTER);
        send_cfg(CFG_ROWS_IN_USE, 8'h01);
        send_cfg(4'hF, 8'h03);              // unknown index: ignored
        send_char(8'h71);
        send_char(8'h72);
        send_char(KEY_ENTER);               // modulo one line

        // random phases over several geometries, out-of-range ones included
        phase_cols = '{5'd20, 5'd1, 5'd1, 5'd20, 5'd0, 5'd31, 5'd5, 5'($urandom_range(31))};
        phase_rows = '{3'd4, 3'd1, 3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'($urandom_range(7))};
        for (int p = 0; p < 8; p++) begin
            send_cfg(CFG_COLUMNS_IN_USE, {3'($urandom_range(7)), phase_cols[p]});
            send_cfg(CFG_ROWS_IN_USE, {5'($urandom_range(31)), phase_rows[p]});
            send_cfg(4'($urandom_range(15, 2)), 8'($urandom_range(255)));
            for (int k = 0; k < PHASE_CHARS; k++)
                send_char(random_char());
        end

        // reset held, then released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (send_queue.size() != 0 || lcd_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters and %0d register writes over 8 geometries;",
                 chars_taken, cfg_taken);
        $display("checked %0d LCD writes, %0d mismatches.", writes_seen, mismatches);
        if (mismatches == 0 && lcd_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
